[src/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition that holds at every clock edge out of reset
`define U8D_ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// condition in one cycle that implies another in the next cycle
`define U8D_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

`endif

[src/u8d_pkg.sv]
// package with status codes, byte classes and the queue entry type
`timescale 1ns / 1ps
`default_nettype none

package u8d_pkg;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_LEAD = 3'd1;
    localparam logic [2:0] ST_BAD_CONT = 3'd2;
    localparam logic [2:0] ST_RANGE    = 3'd3;
    localparam logic [2:0] ST_TRUNC    = 3'd4;
    localparam logic [2:0] ST_END      = 3'd5;

    // class of a byte seen as a lead byte
    localparam logic [2:0] CL_ASCII = 3'd0;
    localparam logic [2:0] CL_BAD   = 3'd1;
    localparam logic [2:0] CL_LEAD2 = 3'd2;
    localparam logic [2:0] CL_LEAD3 = 3'd3;
    localparam logic [2:0] CL_LEAD4 = 3'd4;

    // lead bytes that restrict the second byte
    localparam logic [2:0] CK_NONE = 3'd0;
    localparam logic [2:0] CK_E0   = 3'd1;
    localparam logic [2:0] CK_ED   = 3'd2;
    localparam logic [2:0] CK_F0   = 3'd3;
    localparam logic [2:0] CK_F4   = 3'd4;

    localparam int unsigned CP_W  = 21;
    localparam int unsigned CNT_W = 3;
    localparam int unsigned RAW_W = 32;

    typedef struct packed {
        logic       end_mark;
        logic [7:0] data;
        logic [2:0] cls;
        logic       is_cont;
        logic [2:0] chk;
        logic       lt_a0;
        logic       lt_90;
    } t_u8d_req;

endpackage

`default_nettype wire

[src/u8d_front.sv]
// front part: accepts a byte request and classifies it for the back part
`timescale 1ns / 1ps
`default_nettype none

module u8d_front (
    input  wire logic            i_valid,
    input  wire logic [7:0]      i_data,
    input  wire logic            i_last,
    output logic                 o_ready,
    input  wire logic            i_full,
    output logic                 o_push,
    output u8d_pkg::t_u8d_req    o_req
);
    import u8d_pkg::*;

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_req          = '0;
        o_req.end_mark = i_last;
        o_req.data     = i_data;
        o_req.is_cont  = (i_data inside {[8'h80:8'hBF]});
        o_req.lt_a0    = (i_data < 8'hA0);
        o_req.lt_90    = (i_data < 8'h90);
        if (i_data inside {[8'h00:8'h7F]}) begin
            o_req.cls = CL_ASCII;
        end else if (i_data inside {[8'hC2:8'hDF]}) begin
            o_req.cls = CL_LEAD2;
        end else if (i_data inside {[8'hE0:8'hEF]}) begin
            o_req.cls = CL_LEAD3;
        end else if (i_data inside {[8'hF0:8'hF4]}) begin
            o_req.cls = CL_LEAD4;
        end else begin
            o_req.cls = CL_BAD;
        end
        case (i_data)
            8'hE0:   o_req.chk = CK_E0;
            8'hED:   o_req.chk = CK_ED;
            8'hF0:   o_req.chk = CK_F0;
            8'hF4:   o_req.chk = CK_F4;
            default: o_req.chk = CK_NONE;
        endcase
    end

endmodule

`default_nettype wire

[src/u8d_queue.sv]
// short request queue between the front and back parts
`timescale 1ns / 1ps
`default_nettype none

module u8d_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire u8d_pkg::t_u8d_req i_req,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic                   o_valid,
    output u8d_pkg::t_u8d_req      o_req
);
    import u8d_pkg::*;

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_u8d_req      r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count, n_count;
    logic          w_do_push, w_do_pop;

    assign o_full    = (r_count == FULL_CNT);
    assign o_valid   = (r_count != '0);
    assign o_req     = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_IDX) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_IDX) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_req;
        end
    end

endmodule

`default_nettype wire

[src/u8d_back.sv]
// back part: assembles sequences, checks them and holds the result register
`timescale 1ns / 1ps
`default_nettype none

module u8d_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    input  wire u8d_pkg::t_u8d_req          i_req,
    output logic                            o_pop,
    output logic                            o_valid,
    input  wire logic                       i_ready,
    output logic [2:0]                      o_status,
    output logic [u8d_pkg::CP_W-1:0]        o_code_point,
    output logic [u8d_pkg::CNT_W-1:0]       o_byte_count,
    output logic [u8d_pkg::RAW_W-1:0]       o_raw_bytes
);
    import u8d_pkg::*;

    logic [7:0]       r_held [3];
    logic [1:0]       r_cnt, n_cnt;
    logic [1:0]       r_last_idx, n_last_idx;
    logic [2:0]       r_chk, n_chk;
    logic             r_valid, n_valid;
    logic [2:0]       r_status, n_status;
    logic [CP_W-1:0]  r_cp, n_cp;
    logic [CNT_W-1:0] r_nbytes, n_nbytes;
    logic [RAW_W-1:0] r_raw, n_raw;
    logic             w_hold;
    logic             w_range_bad;
    logic [7:0]       w_b;

    assign o_pop        = i_valid && (!r_valid || i_ready);
    assign o_valid      = r_valid;
    assign o_status     = r_status;
    assign o_code_point = r_cp;
    assign o_byte_count = r_nbytes;
    assign o_raw_bytes  = r_raw;
    assign w_b          = i_req.data;

    assign w_range_bad = ((r_chk == CK_E0) && i_req.lt_a0)
                      || ((r_chk == CK_F0) && i_req.lt_90)
                      || ((r_chk == CK_ED) && !i_req.lt_a0)
                      || ((r_chk == CK_F4) && !i_req.lt_90);

    always_comb begin
        n_cnt      = r_cnt;
        n_last_idx = r_last_idx;
        n_chk      = r_chk;
        n_valid    = r_valid && !i_ready;
        n_status   = r_status;
        n_cp       = r_cp;
        n_nbytes   = r_nbytes;
        n_raw      = r_raw;
        w_hold     = 1'b0;
        if (o_pop) begin
            n_valid  = 1'b1;
            n_status = ST_OK;
            n_cp     = '0;
            n_nbytes = '0;
            n_raw    = '0;
            if (i_req.end_mark) begin
                n_status = (r_cnt != 2'd0) ? ST_TRUNC : ST_END;
                n_cnt    = 2'd0;
            end else if (r_cnt == 2'd0) begin
                case (i_req.cls)
                    CL_ASCII: begin
                        n_cp     = CP_W'(w_b);
                        n_nbytes = CNT_W'(1);
                        n_raw    = RAW_W'(w_b);
                    end
                    CL_LEAD2, CL_LEAD3, CL_LEAD4: begin
                        n_valid    = 1'b0;
                        w_hold     = 1'b1;
                        n_cnt      = 2'd1;
                        n_chk      = i_req.chk;
                        n_last_idx = (i_req.cls == CL_LEAD2) ? 2'd1
                                   : (i_req.cls == CL_LEAD3) ? 2'd2 : 2'd3;
                    end
                    default: begin
                        n_status = ST_BAD_LEAD;
                    end
                endcase
            end else if (!i_req.is_cont) begin
                n_status = ST_BAD_CONT;
                n_cnt    = 2'd0;
            end else if ((r_cnt == 2'd1) && w_range_bad) begin
                n_status = ST_RANGE;
                n_cnt    = 2'd0;
            end else if (r_cnt != r_last_idx) begin
                n_valid = 1'b0;
                w_hold  = 1'b1;
                n_cnt   = r_cnt + 2'd1;
            end else begin
                n_cnt    = 2'd0;
                n_nbytes = CNT_W'({1'b0, r_last_idx}) + CNT_W'(1);
                case (r_last_idx)
                    2'd1: begin
                        n_cp  = CP_W'({r_held[0][4:0], w_b[5:0]});
                        n_raw = RAW_W'({w_b, r_held[0]});
                    end
                    2'd2: begin
                        n_cp  = CP_W'({r_held[0][3:0], r_held[1][5:0], w_b[5:0]});
                        n_raw = RAW_W'({w_b, r_held[1], r_held[0]});
                    end
                    default: begin
                        n_cp  = {r_held[0][2:0], r_held[1][5:0], r_held[2][5:0], w_b[5:0]};
                        n_raw = {w_b, r_held[2], r_held[1], r_held[0]};
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= 2'd0;
            r_last_idx <= 2'd1;
            r_chk      <= CK_NONE;
            r_valid    <= 1'b0;
        end else begin
            r_cnt      <= n_cnt;
            r_last_idx <= n_last_idx;
            r_chk      <= n_chk;
            r_valid    <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_cp     <= n_cp;
        r_nbytes <= n_nbytes;
        r_raw    <= n_raw;
        if (w_hold) begin
            r_held[r_cnt] <= w_b;
        end
    end

endmodule

`default_nettype wire

[src/utf8_stream_decoder_unit.sv]
// validating utf-8 stream decoder: one byte or end marker per request
// a result is valid in the cycle after its byte leaves the queue
// throughput: one byte per cycle while the output is not stalled by m_axis_tready
// bytes that only extend a sequence give no result
// reset clears the queue, held count and result valid; held bytes are not cleared
`timescale 1ns / 1ps
`default_nettype none

module utf8_stream_decoder_unit #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // data_byte
    input  wire logic        s_axis_tlast,   // end_marker
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [55:0]      m_axis_tdata,   // code_point, byte_count, raw_bytes
    output logic [2:0]       m_axis_tuser    // status
);
    import u8d_pkg::*;

    t_u8d_req         w_push_req, w_pop_req;
    logic             w_push, w_full, w_pop, w_q_valid;
    logic [CP_W-1:0]  w_cp;
    logic [CNT_W-1:0] w_nbytes;
    logic [RAW_W-1:0] w_raw;

    u8d_front u_front (
        .i_valid (s_axis_tvalid),
        .i_data  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .o_ready (s_axis_tready),
        .i_full  (w_full),
        .o_push  (w_push),
        .o_req   (w_push_req)
    );

    u8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_req   (w_push_req),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_req   (w_pop_req)
    );

    u8d_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_q_valid),
        .i_req        (w_pop_req),
        .o_pop        (w_pop),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_status     (m_axis_tuser),
        .o_code_point (w_cp),
        .o_byte_count (w_nbytes),
        .o_raw_bytes  (w_raw)
    );

    assign m_axis_tdata = {w_raw, w_nbytes, w_cp};

endmodule

`default_nettype wire

[src/u8d_checker.sv]
// port-level checker for the decoder and its bind to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module u8d_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [55:0] m_axis_tdata,
    input wire logic [2:0]  m_axis_tuser
);
    import u8d_pkg::*;

    `U8D_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

    `U8D_ASSERT_ALWAYS(a_err_zero, i_clk, i_rst_n, !m_axis_tvalid || (m_axis_tuser == ST_OK) || (m_axis_tdata == '0), "error result carries nonzero data")

    `U8D_ASSERT_ALWAYS(a_count_ok, i_clk, i_rst_n, !m_axis_tvalid || (m_axis_tuser != ST_OK) || ((m_axis_tdata[23:21] != 3'd0) && (m_axis_tdata[23:21] <= 3'd4)), "character with bad byte count")

    `U8D_ASSERT_ALWAYS(a_ascii, i_clk, i_rst_n, !m_axis_tvalid || (m_axis_tuser != ST_OK) || (m_axis_tdata[23:21] != 3'd1) || ((m_axis_tdata[55:32] == '0) && (m_axis_tdata[31:24] == m_axis_tdata[7:0]) && (m_axis_tdata[20:8] == '0)), "one-byte character mismatch")

endmodule

bind utf8_stream_decoder_unit u8d_checker u_u8d_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
